[rtl/cle_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cle_pkg
// Shared constants and types of the console line editor.
// ----------------------------------------------------------------------------
package cle_pkg;

    localparam int LINE_CAPACITY = 32;
    localparam int FILL_W        = $clog2(LINE_CAPACITY);
    localparam int IDLE_W        = 20;
    localparam int LIMIT_W       = 6;
    localparam int TMO_W         = 16;
    localparam int LEN_W         = 5;
    localparam int DATA_W        = 8;
    localparam int APB_DW        = 32;
    localparam int APB_AW        = 3;
    localparam int ECHO_W        = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32);

    localparam logic [DATA_W-1:0] CH_BS    = 8'h08;
    localparam logic [DATA_W-1:0] CH_LF    = 8'h0A;
    localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;
    localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;
    localparam logic [DATA_W-1:0] CH_TILDE = 8'h7E;
    localparam logic [DATA_W-1:0] CH_DEL   = 8'h7F;

    typedef enum logic [0:0] {
        CMD_BYTE = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef enum logic [0:0] {
        REG_LINE_LIMIT = 1'b0,
        REG_TIMEOUT_MS = 1'b1
    } t_reg;

    typedef enum logic [1:0] {
        KIND_ECHO = 2'd0,
        KIND_CHAR = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        STAT_TERM    = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_TIMEOUT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ECHO,
        ST_RD,
        ST_CHAR,
        ST_END
    } t_state;

endpackage
`default_nettype wire

[rtl/console_line_editor.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// console_line_editor
// Line assembly with echo: stores printable bytes, handles backspace, and
// dumps the line (characters, then an end request) on terminator, full
// buffer or idle timeout.
// Each result is registered in the output register. A stored byte is
// echoed, an erase echoes backspace, space, backspace; a line end sends any
// echo, then a read state (ST_RD) of the line store RAM, one character per
// stored byte and an end request. A new request is taken only while the
// sequencer is idle, so echoes, a line dump and output stalls hold it off.
// Reset (sync, active low): empty line, idle count 0, line_limit 32,
// timeout 0; the line store itself is not cleared.
// ----------------------------------------------------------------------------
module console_line_editor (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request in
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_command,
    input  wire logic [cle_pkg::DATA_W-1:0]    i_rx_byte,
    // results out
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [1:0]                    o_kind,
    output logic      [cle_pkg::DATA_W-1:0]    o_data_byte,
    output logic      [cle_pkg::LEN_W-1:0]     o_line_length,
    output logic      [1:0]                    o_end_status,
    output logic                               o_last,
    // APB config
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cle_pkg::APB_AW-1:0]    paddr,
    input  wire logic [cle_pkg::APB_DW-1:0]    pwdata,
    output logic      [cle_pkg::APB_DW-1:0]    prdata,
    output logic                               pready
);

    localparam int FW = cle_pkg::FILL_W;
    localparam int IW = cle_pkg::IDLE_W;

    // config
    logic [cle_pkg::LIMIT_W-1:0] r_line_limit;
    logic [cle_pkg::TMO_W-1:0]   r_timeout_ms;
    logic [IW-1:0]               r_tmo_ticks;
    logic                        w_cfg_wr;
    logic [IW-1:0]               w_tmo_ext;

    // line state
    cle_pkg::t_state      r_state, n_state;
    logic [FW-1:0]        r_fill, n_fill;
    logic [IW-1:0]        r_idle, n_idle;
    logic [cle_pkg::ECHO_W-1:0] r_echo_left, n_echo_left;
    logic                 r_echo_bs, n_echo_bs;
    logic [cle_pkg::DATA_W-1:0] r_echo_byte;
    logic                 r_fin, n_fin;
    logic [FW-1:0]        r_fin_len, n_fin_len;
    cle_pkg::t_status     r_fin_status, n_fin_status;
    logic [FW-1:0]        r_rd_idx;

    // output register
    logic                        r_out_valid;
    cle_pkg::t_kind              r_out_kind;
    logic [cle_pkg::DATA_W-1:0]  r_out_data;
    logic [cle_pkg::LEN_W-1:0]   r_out_len;
    cle_pkg::t_status            r_out_status;
    logic                        r_out_last;

    // decode
    logic                 w_acc;
    logic                 w_load;
    logic                 w_is_term, w_is_bs, w_is_print;
    logic                 w_store, w_unstore;
    logic [FW-1:0]        w_lim_m1;
    logic [FW-1:0]        w_fill_after;
    logic [IW-1:0]        w_idle_inc;
    logic [FW-1:0]        w_last_idx;
    logic [cle_pkg::DATA_W-1:0] w_echo_data;

    // result generation
    logic                        w_emit;
    cle_pkg::t_kind              w_emit_kind;
    logic [cle_pkg::DATA_W-1:0]  w_emit_data;
    logic [cle_pkg::LEN_W-1:0]   w_emit_len;
    cle_pkg::t_status            w_emit_status;
    logic                        w_emit_last;
    logic                        w_rd_en;
    logic [FW-1:0]               w_rd_addr;
    logic [cle_pkg::DATA_W-1:0]  w_rd_data;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_tmo_ext = IW'(pwdata[cle_pkg::TMO_W-1:0]);

    always_comb begin
        case (cle_pkg::t_reg'(paddr[2]))
            cle_pkg::REG_LINE_LIMIT:
                prdata = cle_pkg::APB_DW'(r_line_limit);
            cle_pkg::REG_TIMEOUT_MS:
                prdata = cle_pkg::APB_DW'(r_timeout_ms);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_limit <= cle_pkg::LIMIT_RESET;
            r_timeout_ms <= '0;
            r_tmo_ticks  <= '0;
        end else if (w_cfg_wr) begin
            case (cle_pkg::t_reg'(paddr[2]))
                cle_pkg::REG_LINE_LIMIT: begin
                    r_line_limit <= pwdata[cle_pkg::LIMIT_W-1:0];
                end
                cle_pkg::REG_TIMEOUT_MS: begin
                    r_timeout_ms <= pwdata[cle_pkg::TMO_W-1:0];
                    r_tmo_ticks  <= (w_tmo_ext << 3) + (w_tmo_ext << 1);
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- request decode ----------------
    assign o_in_ready = (r_state == cle_pkg::ST_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_load     = !r_out_valid || i_out_ready;

    always_comb begin
        if (r_line_limit < cle_pkg::LIMIT_W'(2)) begin
            w_lim_m1 = FW'(1);
        end else if (r_line_limit > cle_pkg::LIMIT_W'(cle_pkg::LINE_CAPACITY)) begin
            w_lim_m1 = FW'(cle_pkg::LINE_CAPACITY - 1);
        end else begin
            w_lim_m1 = FW'(r_line_limit - cle_pkg::LIMIT_W'(1));
        end
    end

    assign w_is_term  = (i_rx_byte == cle_pkg::CH_CR) || (i_rx_byte == cle_pkg::CH_LF);
    assign w_is_bs    = (i_rx_byte == cle_pkg::CH_BS) || (i_rx_byte == cle_pkg::CH_DEL);
    assign w_is_print = i_rx_byte inside {[cle_pkg::CH_SPACE:cle_pkg::CH_TILDE]};
    assign w_unstore  = w_is_bs && (r_fill != '0);
    assign w_store    = w_is_print && (r_fill < w_lim_m1);
    assign w_idle_inc = (&r_idle) ? r_idle : r_idle + IW'(1);

    always_comb begin
        if (w_unstore) begin
            w_fill_after = r_fill - FW'(1);
        end else if (w_store) begin
            w_fill_after = r_fill + FW'(1);
        end else begin
            w_fill_after = r_fill;
        end
    end

    always_comb begin
        n_fill       = r_fill;
        n_idle       = r_idle;
        n_echo_left  = '0;
        n_echo_bs    = 1'b0;
        n_fin        = 1'b0;
        n_fin_len    = r_fill;
        n_fin_status = cle_pkg::STAT_TERM;
        if (cle_pkg::t_cmd'(i_command) == cle_pkg::CMD_TICK) begin
            n_idle = w_idle_inc;
            if ((r_timeout_ms != '0) && (w_idle_inc >= r_tmo_ticks)) begin
                n_fin        = 1'b1;
                n_fin_status = cle_pkg::STAT_TIMEOUT;
            end
        end else begin
            n_idle = '0;
            if (w_is_term) begin
                n_fin = 1'b1;
            end else begin
                n_fill    = w_fill_after;
                n_fin_len = w_fill_after;
                if (w_unstore) begin
                    n_echo_left = cle_pkg::ECHO_W'(3);
                    n_echo_bs   = 1'b1;
                end else if (w_store) begin
                    n_echo_left = cle_pkg::ECHO_W'(1);
                end
                if (w_fill_after >= w_lim_m1) begin
                    n_fin        = 1'b1;
                    n_fin_status = cle_pkg::STAT_FULL;
                end
            end
        end
        if (n_fin) begin
            n_fill = '0;
            n_idle = '0;
        end
    end

    // ---------------- sequencer ----------------
    assign w_last_idx = r_fin_len - FW'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            cle_pkg::ST_IDLE: begin
                if (w_acc) begin
                    if (n_echo_left != '0) begin
                        n_state = cle_pkg::ST_ECHO;
                    end else if (n_fin) begin
                        n_state = (n_fin_len != '0) ? cle_pkg::ST_RD : cle_pkg::ST_END;
                    end
                end
            end
            cle_pkg::ST_ECHO: begin
                if (w_load && (r_echo_left == cle_pkg::ECHO_W'(1))) begin
                    if (r_fin) begin
                        n_state = (r_fin_len != '0) ? cle_pkg::ST_RD : cle_pkg::ST_END;
                    end else begin
                        n_state = cle_pkg::ST_IDLE;
                    end
                end
            end
            cle_pkg::ST_RD: begin
                n_state = cle_pkg::ST_CHAR;
            end
            cle_pkg::ST_CHAR: begin
                if (w_load && (r_rd_idx == w_last_idx)) begin
                    n_state = cle_pkg::ST_END;
                end
            end
            cle_pkg::ST_END: begin
                if (w_load) begin
                    n_state = cle_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cle_pkg::ST_IDLE;
            end
        endcase
    end

    assign w_echo_data = !r_echo_bs ? r_echo_byte :
                         (r_echo_left == cle_pkg::ECHO_W'(2)) ? cle_pkg::CH_SPACE :
                         cle_pkg::CH_BS;

    always_comb begin
        w_emit        = 1'b0;
        w_emit_kind   = cle_pkg::KIND_ECHO;
        w_emit_data   = '0;
        w_emit_len    = '0;
        w_emit_status = cle_pkg::STAT_TERM;
        w_emit_last   = 1'b0;
        w_rd_en       = 1'b0;
        w_rd_addr     = r_rd_idx;
        case (r_state)
            cle_pkg::ST_ECHO: begin
                w_emit      = 1'b1;
                w_emit_data = w_echo_data;
                w_emit_last = (r_echo_left == cle_pkg::ECHO_W'(1)) && !r_fin;
            end
            cle_pkg::ST_RD: begin
                w_rd_en = 1'b1;
            end
            cle_pkg::ST_CHAR: begin
                w_emit      = 1'b1;
                w_emit_kind = cle_pkg::KIND_CHAR;
                w_emit_data = w_rd_data;
                w_rd_en     = w_load && (r_rd_idx != w_last_idx);
                w_rd_addr   = r_rd_idx + FW'(1);
            end
            cle_pkg::ST_END: begin
                w_emit        = 1'b1;
                w_emit_kind   = cle_pkg::KIND_END;
                w_emit_len    = cle_pkg::LEN_W'(r_fin_len);
                w_emit_status = r_fin_status;
                w_emit_last   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    cle_ram #(
        .WIDTH (cle_pkg::DATA_W),
        .DEPTH (cle_pkg::LINE_CAPACITY)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (w_acc && (cle_pkg::t_cmd'(i_command) == cle_pkg::CMD_BYTE) &&
                  !w_is_term && w_store),
        .i_waddr (r_fill),
        .i_wdata (i_rx_byte),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cle_pkg::ST_IDLE;
            r_fill      <= '0;
            r_idle      <= '0;
            r_echo_left <= '0;
            r_echo_bs   <= 1'b0;
            r_fin       <= 1'b0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_acc) begin
                r_fill      <= n_fill;
                r_idle      <= n_idle;
                r_echo_left <= n_echo_left;
                r_echo_bs   <= n_echo_bs;
                r_fin       <= n_fin;
                r_rd_idx    <= '0;
            end else if (w_load && (r_state == cle_pkg::ST_ECHO)) begin
                r_echo_left <= r_echo_left - cle_pkg::ECHO_W'(1);
            end else if (w_load && (r_state == cle_pkg::ST_CHAR)) begin
                r_rd_idx <= r_rd_idx + FW'(1);
            end
            if (w_load) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_echo_byte  <= i_rx_byte;
            r_fin_len    <= n_fin_len;
            r_fin_status <= n_fin_status;
        end
        if (w_load) begin
            r_out_kind   <= w_emit_kind;
            r_out_data   <= w_emit_data;
            r_out_len    <= w_emit_len;
            r_out_status <= w_emit_status;
            r_out_last   <= w_emit_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_data_byte   = r_out_data;
    assign o_line_length = r_out_len;
    assign o_end_status  = r_out_status;
    assign o_last        = r_out_last;

    // ---------------- assertions ----------------
    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cle_pkg::ST_CHAR) |-> (r_rd_idx < r_fin_len))
        else $error("line read index past stored length");

    a_dump_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == cle_pkg::ST_RD) || (r_state == cle_pkg::ST_END)) |->
        ((r_fill == '0) && (r_idle == '0)))
        else $error("line state not cleared during dump");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == cle_pkg::KIND_END)) |-> o_last)
        else $error("line end request without last flag");

endmodule
`default_nettype wire

[rtl/cle_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cle_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for console_line_editor: drives received bytes and idle ticks
// through the request channel under bursty traffic and receiver stalls, keeps
// its own line-editor model to predict every echo, line character and line
// end, and checks each result in order. Directed tests cover printable
// extremes, erase, dropped bytes, full buffer, idle timeout and a limit lowered
// below the fill; random phases send whole lines across several settings.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned IDLE_MAX   = (1 << cle_pkg::IDLE_W) - 1;
    localparam int          SETTLE_CYC = 60;

    typedef struct packed {
        cle_pkg::t_kind             kind;
        logic [cle_pkg::DATA_W-1:0] data;
        logic [cle_pkg::LEN_W-1:0]  len;
        cle_pkg::t_status           status;
        logic                       last;
    } t_line_result;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    wire                           o_in_ready;
    logic                          i_command;
    logic [cle_pkg::DATA_W-1:0]    i_rx_byte;
    wire                           o_out_valid;
    logic                          i_out_ready;
    wire  [1:0]                    o_kind;
    wire  [cle_pkg::DATA_W-1:0]    o_data_byte;
    wire  [cle_pkg::LEN_W-1:0]     o_line_length;
    wire  [1:0]                    o_end_status;
    wire                           o_last;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [cle_pkg::APB_AW-1:0]    paddr;
    logic [cle_pkg::APB_DW-1:0]    pwdata;
    wire  [cle_pkg::APB_DW-1:0]    prdata;
    wire                           pready;

    console_line_editor DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_data_byte   (o_data_byte),
        .o_line_length (o_line_length),
        .o_end_status  (o_end_status),
        .o_last        (o_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // line editor model state
    logic [cle_pkg::DATA_W-1:0] line_buf [cle_pkg::LINE_CAPACITY];
    int unsigned       fill_cnt;
    int unsigned       idle_cnt;
    int unsigned       cfg_limit;
    int unsigned       cfg_timeout;

    t_line_result      line_results [$];
    t_line_result      want_r;
    t_line_result      got_r;
    int                mismatch_count;
    int                requests_sent;
    int                results_checked;
    int                ends_by_status [3];
    int                burst_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[console_line_editor] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic int unsigned eff_limit(input int unsigned lim);
        return (lim < 2) ? 2 :
               ((lim > cle_pkg::LINE_CAPACITY) ? cle_pkg::LINE_CAPACITY : lim);
    endfunction

    task automatic push_result(input cle_pkg::t_kind k,
                               input logic [cle_pkg::DATA_W-1:0] d,
                               input logic [cle_pkg::LEN_W-1:0] n,
                               input cle_pkg::t_status s);
        line_results.push_back('{kind: k, data: d, len: n, status: s, last: 1'b0});
    endtask

    task automatic close_line(input cle_pkg::t_status st);
        for (int i = 0; i < fill_cnt; i++)
            push_result(cle_pkg::KIND_CHAR, line_buf[i], '0, cle_pkg::STAT_TERM);
        push_result(cle_pkg::KIND_END, '0, cle_pkg::LEN_W'(fill_cnt), st);
        fill_cnt = 0;
        idle_cnt = 0;
    endtask

    task automatic predict_request(input cle_pkg::t_cmd cmd,
                                   input logic [cle_pkg::DATA_W-1:0] ch);
        int unsigned lim;
        int          first;
        int          idx;
        first = line_results.size();
        lim   = eff_limit(cfg_limit);
        if (cmd == cle_pkg::CMD_TICK) begin
            if (idle_cnt < IDLE_MAX)
                idle_cnt++;
            if (cfg_timeout != 0 && idle_cnt >= cfg_timeout * 10)
                close_line(cle_pkg::STAT_TIMEOUT);
        end else begin
            idle_cnt = 0;
            if (ch == cle_pkg::CH_CR || ch == cle_pkg::CH_LF) begin
                close_line(cle_pkg::STAT_TERM);
            end else begin
                if (ch == cle_pkg::CH_BS || ch == cle_pkg::CH_DEL) begin
                    if (fill_cnt > 0) begin
                        fill_cnt--;
                        push_result(cle_pkg::KIND_ECHO, cle_pkg::CH_BS, '0,
                                    cle_pkg::STAT_TERM);
                        push_result(cle_pkg::KIND_ECHO, cle_pkg::CH_SPACE, '0,
                                    cle_pkg::STAT_TERM);
                        push_result(cle_pkg::KIND_ECHO, cle_pkg::CH_BS, '0,
                                    cle_pkg::STAT_TERM);
                    end
                end else if (ch >= cle_pkg::CH_SPACE && ch <= cle_pkg::CH_TILDE) begin
                    if (fill_cnt < lim - 1) begin
                        line_buf[fill_cnt] = ch;
                        fill_cnt++;
                        push_result(cle_pkg::KIND_ECHO, ch, '0, cle_pkg::STAT_TERM);
                    end
                end
                if (fill_cnt >= lim - 1)
                    close_line(cle_pkg::STAT_FULL);
            end
        end
        if (line_results.size() > first) begin
            idx = line_results.size() - 1;
            line_results[idx].last = 1'b1;
        end
    endtask

    // sender: bursts of requests separated by random gaps
    task automatic send_request(input cle_pkg::t_cmd cmd,
                                input logic [cle_pkg::DATA_W-1:0] ch);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_rx_byte  <= ch;
        predict_request(cmd, ch);
        requests_sent++;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_ticks(input int unsigned tmo);
        int n;
        n = (tmo != 0 && tmo <= 4) ? $urandom_range(tmo * 10 - 3, tmo * 10 + 1)
                                   : $urandom_range(1, 5);
        repeat (n) send_request(cle_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (line_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic apb_write(input cle_pkg::t_reg r, input logic [cle_pkg::APB_DW-1:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            cle_pkg::REG_LINE_LIMIT: cfg_limit   = v[cle_pkg::LIMIT_W-1:0];
            cle_pkg::REG_TIMEOUT_MS: cfg_timeout = v[cle_pkg::TMO_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int unsigned lim, input int unsigned tmo);
        wait_results_drained();
        apb_write(cle_pkg::REG_LINE_LIMIT, cle_pkg::APB_DW'(lim));
        apb_write(cle_pkg::REG_TIMEOUT_MS, cle_pkg::APB_DW'(tmo));
    endtask

    task automatic test_echo_and_terminators();
        set_config(32, 0);
        send_request(cle_pkg::CMD_BYTE, cle_pkg::CH_SPACE);
        send_request(cle_pkg::CMD_BYTE, cle_pkg::CH_TILDE);
        send_request(cle_pkg::CMD_BYTE, 8'h4B);
        send_request(cle_pkg::CMD_BYTE, cle_pkg::CH_CR);
        send_request(cle_pkg::CMD_BYTE, cle_pkg::CH_LF);
    endtask

    task automatic test_erase();
        send_request(cle_pkg::CMD_BYTE, cle_pkg::CH_BS);
        send_request(cle_pkg::CMD_BYTE, 8'h61);
        send_request(cle_pkg::CMD_BYTE, 8'h62);
        send_request(cle_pkg::CMD_BYTE, cle_pkg::CH_DEL);
        send_request(cle_pkg::CMD_BYTE, cle_pkg::CH_BS);
        send_request(cle_pkg::CMD_BYTE, cle_pkg::CH_DEL);
        send_request(cle_pkg::CMD_BYTE, 8'h7A);
        send_request(cle_pkg::CMD_BYTE, cle_pkg::CH_LF);
    endtask

    task automatic test_dropped_bytes();
        send_request(cle_pkg::CMD_BYTE, 8'h00);
        send_request(cle_pkg::CMD_BYTE, 8'h80);
        send_request(cle_pkg::CMD_BYTE, 8'hFF);
        send_request(cle_pkg::CMD_BYTE, 8'h1F);
        send_request(cle_pkg::CMD_TICK, 8'hA5);
        send_request(cle_pkg::CMD_BYTE, 8'h71);
        send_request(cle_pkg::CMD_BYTE, cle_pkg::CH_CR);
    endtask

    task automatic test_buffer_full();
        set_config(2, 0);
        send_request(cle_pkg::CMD_BYTE, 8'h78);
        set_config(0, 0);
        send_request(cle_pkg::CMD_BYTE, 8'h79);
        wait_results_drained();
        // upper bits of the write data are not part of the register
        apb_write(cle_pkg::REG_LINE_LIMIT, 32'hA5A5_A5C4);
        send_request(cle_pkg::CMD_BYTE, 8'h61);
        send_request(cle_pkg::CMD_BYTE, 8'h62);
        send_request(cle_pkg::CMD_BYTE, 8'h63);
    endtask

    task automatic test_idle_timeout();
        set_config(32, 1);
        send_request(cle_pkg::CMD_BYTE, 8'h68);
        repeat (9) send_request(cle_pkg::CMD_TICK, 8'h00);
        send_request(cle_pkg::CMD_BYTE, 8'h01);
        repeat (10) send_request(cle_pkg::CMD_TICK, 8'hFF);
    endtask

    task automatic test_limit_lowered();
        set_config(32, 0);
        repeat (4) send_request(cle_pkg::CMD_BYTE, 8'($urandom_range(32, 126)));
        set_config(3, 0);
        send_request(cle_pkg::CMD_TICK, 8'h00);
        send_request(cle_pkg::CMD_BYTE, cle_pkg::CH_DEL);
        set_config(32, 0);
        repeat (5) send_request(cle_pkg::CMD_BYTE, 8'($urandom_range(32, 126)));
        set_config(4, 0);
        send_request(cle_pkg::CMD_BYTE, 8'h02);
    endtask

    // mostly whole lines with random content, the rest noise
    task automatic test_random_lines(input int unsigned lim, input int unsigned tmo,
                                     input int quota);
        int first_req;
        int span;
        int sel;
        set_config(lim, tmo);
        first_req = requests_sent;
        while (requests_sent - first_req < quota) begin
            if ($urandom_range(0, 9) < 7) begin
                span = $urandom_range(0, eff_limit(lim) + 1);
                if (span > quota - (requests_sent - first_req))
                    span = quota - (requests_sent - first_req);
                for (int k = 0; k < span; k++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_request(cle_pkg::CMD_BYTE,
                                     $urandom_range(0, 1) ? cle_pkg::CH_BS : cle_pkg::CH_DEL);
                    else
                        send_request(cle_pkg::CMD_BYTE, 8'($urandom_range(32, 126)));
                end
                sel = $urandom_range(0, 3);
                if (sel < 2) begin
                    send_request(cle_pkg::CMD_BYTE, (sel == 0) ? cle_pkg::CH_CR : cle_pkg::CH_LF);
                end else if (sel == 2) begin
                    send_ticks(tmo);
                end
            end else if ($urandom_range(0, 1) == 1) begin
                send_request(cle_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
            end else begin
                send_ticks(tmo);
            end
        end
    endtask

    // receiver stall pattern
    initial begin : out_stall_pattern
        int mode;
        int span;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 80);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= ~i_out_ready;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (line_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d data %h",
                                          o_kind, o_data_byte));
            end else begin
                want_r = line_results.pop_front();
                got_r  = '{kind: cle_pkg::t_kind'(o_kind), data: o_data_byte,
                           len: o_line_length,
                           status: cle_pkg::t_status'(o_end_status), last: o_last};
                results_checked++;
                if (want_r.kind == cle_pkg::KIND_END)
                    ends_by_status[want_r.status]++;
                if (got_r.kind !== want_r.kind || got_r.data !== want_r.data ||
                    got_r.len !== want_r.len || got_r.status !== want_r.status ||
                    got_r.last !== want_r.last)
                    report_mismatch($sformatf(
                        "got kind %0d data %h len %0d st %0d last %b, want %0d %h %0d %0d %b",
                        got_r.kind, got_r.data, got_r.len, got_r.status, got_r.last,
                        want_r.kind, want_r.data, want_r.len, want_r.status, want_r.last));
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_command   = 1'b0;
        i_rx_byte   = '0;
        i_out_ready = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        fill_cnt    = 0;
        idle_cnt    = 0;
        cfg_limit   = 32;
        cfg_timeout = 0;
        burst_left  = 0;
        mismatch_count  = 0;
        requests_sent   = 0;
        results_checked = 0;
        ends_by_status  = '{0, 0, 0};
        foreach (line_buf[i]) line_buf[i] = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_echo_and_terminators();
        test_erase();
        test_dropped_bytes();
        test_buffer_full();
        test_idle_timeout();
        test_limit_lowered();
        test_random_lines(32, 0, 12);
        test_random_lines(63, 1, 12);
        test_random_lines(5, 0, 8);
        test_random_lines(1, 0, 6);
        test_random_lines(8, 65535, 8);

        wait_results_drained();
        if (line_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", line_results.size()));
        $display("run: %0d requests sent, %0d results checked",
                 requests_sent, results_checked);
        $display("line ends: %0d terminator, %0d buffer full, %0d idle timeout",
                 ends_by_status[cle_pkg::STAT_TERM], ends_by_status[cle_pkg::STAT_FULL],
                 ends_by_status[cle_pkg::STAT_TIMEOUT]);
        if (mismatch_count == 0)
            $display("[console_line_editor] OK");
        else
            $display("[console_line_editor] ERROR");
        $finish;
    end

endmodule
